/* sv/fsp_pkg.sv */
// Shared constants and types for the flow sensor frame parser.
`timescale 1ns / 1ps

package fsp_pkg;

   // Frame marker bytes
   localparam logic [7:0] HdrFirst   = 8'hFE;
   localparam logic [7:0] HdrSecond  = 8'h0A;
   localparam logic [7:0] FooterGood = 8'h55;

   // Frame position codes
   localparam int unsigned PosWidth = 4;
   localparam logic [PosWidth-1:0] PosHunt     = 4'd0;
   localparam logic [PosWidth-1:0] PosHdr2     = 4'd1;
   localparam logic [PosWidth-1:0] PosPayFirst = 4'd2;
   localparam logic [PosWidth-1:0] PosPayLast  = 4'd11;
   localparam logic [PosWidth-1:0] PosChecksum = 4'd12;
   localparam logic [PosWidth-1:0] PosFooter   = 4'd13;

   // Payload store geometry
   localparam int unsigned PayloadLen = 10;
   localparam int unsigned PayIdxWidth = $clog2(PayloadLen);

   // Decoded motion result
   typedef struct packed {
      logic signed [15:0] motion_x;
      logic signed [15:0] motion_y;
      logic [15:0]        interval_us;
      logic               interval_ok;
      logic [7:0]         surf_quality;
      logic [7:0]         hw_version;
   } result_type;

endpackage

/* sv/flow_sensor_frame_parser_top.sv */
// Top level of the flow sensor frame parser: request register, core, result register.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_rx_byte
//   rsp     | out       | rsp_valid, rsp_stall, rsp_motion_x, rsp_motion_y, rsp_interval_us,
//           |           | rsp_interval_ok, rsp_surf_quality, rsp_hw_version
//
// One request per cycle while req_stall is low. A byte is registered on acceptance and
// stepped through the core when it is not stalled; a good footer's result is then
// registered in the result register.
// Reset clears the frame position, checksum and both valid flags; the payload store is
// written only by payload bytes. A stalled result blocks the core step only while the
// result register is full, and the request register then raises req_stall.
`timescale 1ns / 1ps

module flow_sensor_frame_parser_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_motion_x,
   output logic signed [15:0] rsp_motion_y,
   output logic [15:0]        rsp_interval_us,
   output logic               rsp_interval_ok,
   output logic [7:0]         rsp_surf_quality,
   output logic [7:0]         rsp_hw_version
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                advance;
   logic                core_valid;
   fsp_pkg::result_type core_result;
   logic                rsp_valid_ff, rsp_valid_in;
   fsp_pkg::result_type rsp_ff;

   // Step the core unless a full result register is stalled
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Request register
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   fsp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   // Result register: load on a good footer, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (core_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_valid) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motion_x     = rsp_ff.motion_x;
   assign rsp_motion_y     = rsp_ff.motion_y;
   assign rsp_interval_us  = rsp_ff.interval_us;
   assign rsp_interval_ok  = rsp_ff.interval_ok;
   assign rsp_surf_quality = rsp_ff.surf_quality;
   assign rsp_hw_version   = rsp_ff.hw_version;

endmodule

/* sv/fsp_core.sv */
// Frame tracking state, payload store and result decode for one byte a step.
`timescale 1ns / 1ps

module fsp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output logic               result_valid,
   output fsp_pkg::result_type result
);

   logic [fsp_pkg::PosWidth-1:0]    pos_ff, pos_in;
   logic [7:0]                      xor_ff, xor_in;
   logic [7:0]                      store_ff [fsp_pkg::PayloadLen];
   logic                            store_we;
   logic [fsp_pkg::PosWidth-1:0]    pos_off;
   logic [fsp_pkg::PayIdxWidth-1:0] store_idx;

   // Payload slot for the current position
   assign pos_off   = pos_ff - fsp_pkg::PosPayFirst;
   assign store_idx = pos_off[fsp_pkg::PayIdxWidth-1:0];

   // Advance the frame position for the incoming byte
   always_comb begin
      pos_in       = pos_ff;
      xor_in       = xor_ff;
      store_we     = 1'b0;
      result_valid = 1'b0;
      unique case (pos_ff) inside
         fsp_pkg::PosHunt: begin
            if (rx_byte == fsp_pkg::HdrFirst) begin
               pos_in = fsp_pkg::PosHdr2;
               xor_in = 8'd0;
            end
         end
         fsp_pkg::PosHdr2: begin
            pos_in = (rx_byte == fsp_pkg::HdrSecond) ? fsp_pkg::PosPayFirst
                                                     : fsp_pkg::PosHunt;
         end
         [fsp_pkg::PosPayFirst:fsp_pkg::PosPayLast]: begin
            store_we = 1'b1;
            xor_in   = xor_ff ^ rx_byte;
            pos_in   = pos_ff + 1'b1;
         end
         fsp_pkg::PosChecksum: begin
            pos_in = (xor_ff == rx_byte) ? fsp_pkg::PosFooter : fsp_pkg::PosHunt;
         end
         default: begin
            // Footer position, and the unused codes above it
            pos_in       = fsp_pkg::PosHunt;
            result_valid = step && (rx_byte == fsp_pkg::FooterGood);
         end
      endcase
   end

   // Hold state unless a request is stepped through
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= fsp_pkg::PosHunt;
         xor_ff <= 8'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         xor_ff <= xor_in;
      end
   end

   // Capture payload bytes
   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[store_idx] <= rx_byte;
      end
   end

   // Decode little-endian fields from the stored payload
   always_comb begin
      result.motion_x     = {store_ff[1], store_ff[0]};
      result.motion_y     = {store_ff[3], store_ff[2]};
      result.interval_us  = {store_ff[5], store_ff[4]};
      result.interval_ok  = ({store_ff[5], store_ff[4]} != 16'd0);
      result.surf_quality = store_ff[8];
      result.hw_version   = store_ff[9];
   end

endmodule
